// ===== rtl/core/mst_pkg.sv =====
// Package with the word types, codes and sizes of the multi-slot interval timer.
package mst_pkg;

   // Number of timer slots in the table.
   localparam int SLOT_COUNT = 8;
   // Width of a slot index; at least one bit so that a single slot still works.
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   // Most expiry reports that one tick word may produce.
   localparam int MAX_RESULTS = 8;
   // Width of the report counter, wide enough to hold MAX_RESULTS itself.
   localparam int RPT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic KIND_ADD_REPLY = 1'b0;
   localparam logic KIND_EXPIRY    = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] interval;
      logic        repeat_mode;
      logic [7:0]  slot_select;
      logic [15:0] elapsed;
   } req_word_type;

   typedef struct packed {
      logic       result_kind;
      logic [2:0] slot_id;
      logic       add_failed;
      logic       last;
   } rsp_word_type;

endpackage

// ===== rtl/core/multi_slot_interval_timer.sv =====
// Multi-slot interval timer: slot table, sequencer and shared compare-subtract unit.
//
// The block keeps a table of SLOT_COUNT timer slots. Request words arrive on the
// req_ channel (valid/ready) and carry an add, remove or tick command. Result words
// leave on the rsp_ channel (valid/ready) from a single output register.
//
// A remove word gives no result. An add word visits the slots in ascending order,
// one per cycle, until it finds a free one, then loads the reply; the reply is
// always marked last and carries add_failed when the table was full.
// A tick word visits every slot once through the one 17-bit compare-subtract unit,
// then ends in a final step that sends the held report, if any, marked last.
// Expiry reports leave in ascending slot order. Each report is held back one
// step so that the final one of the tick can be marked last.
// req_ready is high only while the sequencer is idle, so one word is at work at a
// time. If the receiver stalls rsp_ready, the sequencer waits on the step that
// needs the output register and resumes as soon as it frees; nothing is dropped.
// Synchronous reset frees every slot at once and empties the output register;
// the interval stores hold no reset value and are only read for busy slots.
module multi_slot_interval_timer
   import mst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ADD   = 4'b0010,
      ST_TICK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [15:0] interval_ff, interval_in;
   logic repeat_ff, repeat_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [RPT_W-1:0] n_ff, n_in;

   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [SLOT_COUNT-1:0] repeats_ff, repeats_in;
   logic [15:0] reload_ff [SLOT_COUNT];
   logic [15:0] reload_in [SLOT_COUNT];
   logic [15:0] remain_ff [SLOT_COUNT];
   logic [15:0] remain_in [SLOT_COUNT];

   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic out_free;
   logic req_take;
   logic [16:0] diff;
   logic still_running;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The shared unit: remaining minus elapsed, with the borrow as the compare.
   assign diff = {1'b0, remain_ff[idx_ff]} - {1'b0, elapsed_ff};
   assign still_running = !diff[16] && (diff[15:0] != 16'd0);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      interval_in   = interval_ff;
      repeat_in     = repeat_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      n_in          = n_ff;
      busy_in       = busy_ff;
      repeats_in    = repeats_ff;
      reload_in     = reload_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_word.opcode)
                  OP_ADD: begin
                     interval_in = req_word.interval;
                     repeat_in   = req_word.repeat_mode;
                     idx_in      = '0;
                     state_in    = ST_ADD;
                  end
                  OP_REMOVE: begin
                     if ({1'b0, req_word.slot_select} < 9'(SLOT_COUNT)) begin
                        busy_in[req_word.slot_select[SLOT_W-1:0]]    = 1'b0;
                        repeats_in[req_word.slot_select[SLOT_W-1:0]] = 1'b0;
                     end
                  end
                  OP_TICK: begin
                     elapsed_in    = req_word.elapsed;
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     n_in          = '0;
                     state_in      = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD: begin
            if (!busy_ff[idx_ff]) begin
               if (out_free) begin
                  busy_in[idx_ff]    = 1'b1;
                  repeats_in[idx_ff] = repeat_ff;
                  reload_in[idx_ff]  = interval_ff;
                  remain_in[idx_ff]  = interval_ff;
                  rsp_valid_in       = 1'b1;
                  rsp_word_in        = '{result_kind: KIND_ADD_REPLY, slot_id: 3'(idx_ff),
                                         add_failed: 1'b0, last: 1'b1};
                  state_in           = ST_IDLE;
               end
            end else if (idx_ff == LAST_SLOT) begin
               // Table full: fail reply with slot zero.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{result_kind: KIND_ADD_REPLY, slot_id: 3'd0,
                                   add_failed: 1'b1, last: 1'b1};
                  state_in     = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_TICK: begin
            if (!busy_ff[idx_ff] || still_running) begin
               if (busy_ff[idx_ff]) begin
                  remain_in[idx_ff] = diff[15:0];
               end
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (!(n_ff < RPT_W'(MAX_RESULTS) && pend_valid_ff) || out_free) begin
               // Expiry. The held report goes out with last clear, this one is held.
               if (n_ff < RPT_W'(MAX_RESULTS)) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '{result_kind: KIND_EXPIRY, slot_id: 3'(pend_slot_ff),
                                      add_failed: 1'b0, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_ff;
                  n_in          = n_ff + 1'b1;
               end
               if (repeats_ff[idx_ff]) begin
                  remain_in[idx_ff] = reload_ff[idx_ff];
               end else begin
                  busy_in[idx_ff] = 1'b0;
               end
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '{result_kind: KIND_EXPIRY, slot_id: 3'(pend_slot_ff),
                                 add_failed: 1'b0, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         busy_ff       <= '0;
         repeats_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
         busy_ff       <= busy_in;
         repeats_ff    <= repeats_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers and the interval stores carry no reset.
   always_ff @(posedge clock) begin
      interval_ff  <= interval_in;
      repeat_ff    <= repeat_in;
      elapsed_ff   <= elapsed_in;
      pend_slot_ff <= pend_slot_in;
      rsp_word_ff  <= rsp_word_in;
      reload_ff    <= reload_in;
      remain_ff    <= remain_in;
   end

   // An add reply is always the only, and therefore the last, word of its request.
   a_add_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.result_kind == KIND_ADD_REPLY) |-> rsp_word_ff.last)
      else $error("add reply without last mark");

   // The fail flag appears only on add replies.
   a_fail_only_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.add_failed |-> rsp_word_ff.result_kind == KIND_ADD_REPLY)
      else $error("fail flag on an expiry report");

   // The report counter never passes the report limit.
   a_report_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RPT_W'(MAX_RESULTS))
      else $error("report counter overflow");

   // A held report exists only while a tick is being worked through.
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_TICK) || (state_ff == ST_FLUSH))
      else $error("held report outside a tick");

   // A flush with nothing held returns to idle in the next cycle.
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) && !pend_valid_ff |=> state_ff == ST_IDLE)
      else $error("empty flush did not finish");

endmodule
